@@ sv/espc_pkg.sv @@
package espc_pkg;

  // Counts per tick to rpm: 100 ticks/s * 60 s/min / 1120 counts/rev = 75/14
  localparam logic [6:0]  RpmScale     = 7'd75;
  // floor(y/14) == (y * Recip14) >> Recip14Shift for y below 2^22
  localparam int          Recip14Shift = 30;
  localparam logic [26:0] Recip14      = 27'd76695845;
  // floor(z/10) == (z * Recip10) >> Recip10Shift for z below 2^19
  localparam int          Recip10Shift = 22;
  localparam logic [18:0] Recip10      = 19'd419431;

  localparam logic [14:0] RpmMax       = 15'h7FFF;
  localparam logic [6:0]  DutyMax      = 7'd100;
  localparam int          FracBits     = 24;

  // Integral term limit, +/- 2^48 in Q.24
  localparam logic signed [64:0] TermHi = 65'sh1_0000_0000_0000;
  localparam logic signed [64:0] TermLo = -65'sh1_0000_0000_0000;

  // Register reset values
  localparam logic [31:0] PropGainRst  = 32'd6710886;
  localparam logic [31:0] IntGainRst   = 32'd11744;
  localparam logic [6:0]  BaseDutyRst  = 7'd25;
  localparam logic [14:0] ErrLimitRst  = 15'd20;

  typedef enum logic [1:0] {
    REG_PROP_GAIN,
    REG_INTEGRAL_GAIN_DT,
    REG_BASE_DUTY,
    REG_ERROR_LIMIT
  } reg_index_t;

endpackage

@@ sv/encoder_speed_pi_controller_core.sv @@
// Throughput: one transaction per cycle while the result channel is not
// stalled; six register stages carry the items, and the smoothing and
// integral loops each close within a single stage.
// Reset (rst, synchronous): registers return to their defaults, the previous
// count, smoothed speed and error sum clear to zero, and all stages empty.
module encoder_speed_pi_controller_core
  import espc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Tick input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         enc_count,
  input  logic [8:0]          setpoint_rpm,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [6:0]          duty_percent,
  output logic [14:0]         measured_rpm,
  output logic signed [15:0]  error_rpm,
  output logic                speed_alarm,
  // Register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // ---------------------------------------------------------------------------
  // Register file. Writes complete in the access phase; reads are plain muxes.
  // ---------------------------------------------------------------------------
  logic [31:0] prop_gain;
  logic [31:0] integral_gain_dt;
  logic [6:0]  base_duty;
  logic [14:0] error_limit;
  reg_index_t  reg_sel;
  logic        reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= PropGainRst;
      integral_gain_dt <= IntGainRst;
      base_duty        <= BaseDutyRst;
      error_limit      <= ErrLimitRst;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_PROP_GAIN:        prop_gain        <= pwdata;
        REG_INTEGRAL_GAIN_DT: integral_gain_dt <= pwdata;
        REG_BASE_DUTY:        base_duty        <= pwdata[6:0];
        REG_ERROR_LIMIT:      error_limit      <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PROP_GAIN:        prdata = prop_gain;
      REG_INTEGRAL_GAIN_DT: prdata = integral_gain_dt;
      REG_BASE_DUTY:        prdata = 32'(base_duty);
      REG_ERROR_LIMIT:      prdata = 32'(error_limit);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage flow control. A stage loads when it is empty or its content moves on,
  // so bubbles collapse and input keeps flowing while a result waits.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  assign rdy_out  = !out_valid || !out_stall;
  assign rdy5     = !v5 || rdy_out;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)    v1        <= in_valid;
      if (rdy2)    v2        <= v1;
      if (rdy3)    v3        <= v2;
      if (rdy4)    v4        <= v3;
      if (rdy5)    v5        <= v4;
      if (rdy_out) out_valid <= v5;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: wrapped count difference, its magnitude, scaled by 75.
  // A half-turn difference (0x8000) has the largest magnitude, 32768.
  // ---------------------------------------------------------------------------
  logic [15:0] previous_count;
  logic [15:0] count_diff;
  logic [16:0] count_mag;
  logic [21:0] s1_scaled;
  logic [8:0]  s1_setpoint;

  assign count_diff = enc_count - previous_count;
  assign count_mag  = count_diff[15] ? (17'h10000 - {1'b0, count_diff})
                                     : {1'b0, count_diff};

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count <= '0;
    end else if (rdy1 && in_valid) begin
      previous_count <= enc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_scaled   <= 22'(count_mag) * 22'(RpmScale);
      s1_setpoint <= setpoint_rpm;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divide by 14 through the reciprocal, saturate the raw rpm.
  // ---------------------------------------------------------------------------
  logic [48:0] rpm_prod;
  logic [18:0] rpm_raw;
  logic [14:0] s2_rpm;
  logic [8:0]  s2_setpoint;

  assign rpm_prod = 49'(s1_scaled) * 49'(Recip14);
  assign rpm_raw  = rpm_prod[48:Recip14Shift];

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_rpm      <= (rpm_raw > 19'(RpmMax)) ? RpmMax : rpm_raw[14:0];
      s2_setpoint <= s1_setpoint;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: smoothing filter (7*old + 3*new)/10. The state register is also
  // this stage's payload, so the loop closes within this stage.
  // ---------------------------------------------------------------------------
  logic [14:0] smoothed_rpm;
  logic [18:0] filt_sum;
  logic [37:0] filt_prod;
  logic [8:0]  s3_setpoint;

  assign filt_sum  = 19'(smoothed_rpm) * 19'd7 + 19'(s2_rpm) * 19'd3;
  assign filt_prod = 38'(filt_sum) * 38'(Recip10);

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_rpm <= '0;
    end else if (rdy3 && v2) begin
      smoothed_rpm <= filt_prod[Recip10Shift +: 15];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_setpoint <= s2_setpoint;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: signed error, warning compare, saturating integral.
  // A zero setpoint clears the integral.
  // ---------------------------------------------------------------------------
  logic signed [16:0] err;
  logic [16:0]        abs_err;
  logic               warn;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic signed [31:0] error_sum;
  logic signed [15:0] s4_err;
  logic               s4_warn;
  logic [14:0]        s4_measured;
  logic               s4_zero;

  assign err      = $signed({8'b0, s3_setpoint}) - $signed({2'b0, smoothed_rpm});
  assign abs_err  = err[16] ? 17'(-err) : 17'(err);
  assign warn     = abs_err > 17'(error_limit);
  assign sum_wide = 33'(error_sum) + 33'(err);

  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      // Overflow: saturate toward the sign of the true sum
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (rdy4 && v3) begin
      error_sum <= (s3_setpoint == '0) ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      s4_err      <= err[15:0];
      s4_warn     <= warn;
      s4_measured <= smoothed_rpm;
      s4_zero     <= (s3_setpoint == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: proportional and integral products, registered.
  // ---------------------------------------------------------------------------
  logic signed [32:0] kp_s;
  logic signed [32:0] ki_s;
  logic signed [48:0] pp_full;
  logic signed [64:0] ip_full;
  logic signed [48:0] s5_pp;
  logic signed [64:0] s5_ip;
  logic [6:0]         s5_base;
  logic               s5_zero;
  logic signed [15:0] s5_err;
  logic               s5_warn;
  logic [14:0]        s5_measured;

  assign kp_s    = $signed({1'b0, prop_gain});
  assign ki_s    = $signed({1'b0, integral_gain_dt});
  assign pp_full = 49'(kp_s) * 49'(s4_err);
  assign ip_full = 65'(ki_s) * 65'(error_sum);

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      s5_pp       <= pp_full;
      s5_ip       <= ip_full;
      s5_base     <= base_duty;
      s5_zero     <= s4_zero;
      s5_err      <= s4_err;
      s5_warn     <= s4_warn;
      s5_measured <= s4_measured;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: clamp the integral term, sum in Q.24, truncate and clamp duty.
  // ---------------------------------------------------------------------------
  logic signed [49:0] ip_clamped;
  logic signed [50:0] total;
  logic [26:0]        whole;
  logic [6:0]         duty;

  always_comb begin
    if (s5_ip > TermHi) begin
      ip_clamped = TermHi[49:0];
    end else if (s5_ip < TermLo) begin
      ip_clamped = TermLo[49:0];
    end else begin
      ip_clamped = s5_ip[49:0];
    end
  end

  assign total = $signed({20'b0, s5_base, 24'b0}) + 51'(s5_pp) + 51'(ip_clamped);
  assign whole = total[50:FracBits];

  always_comb begin
    if (s5_zero || total[50]) begin
      duty = '0;
    end else if (whole > 27'(DutyMax)) begin
      duty = DutyMax;
    end else begin
      duty = whole[6:0];
    end
  end

  // Hold the result while stalled; advance when the slot frees up.
  always_ff @(posedge clk) begin
    if (rdy_out && v5) begin
      duty_percent <= duty;
      measured_rpm <= s5_measured;
      error_rpm    <= s5_err;
      speed_alarm  <= s5_warn;
    end
  end

endmodule

@@ bench/tb.sv @@
module tb;
  import espc_pkg::*;

  // One expected controller update, at the widths of the result ports
  typedef struct packed {
    logic [6:0]  duty;
    logic [14:0] rpm;
    logic [15:0] err;
    logic        warn;
  } speed_update_t;

  localparam longint SumHi        = 64'sd2147483647;
  localparam longint SumLo        = -SumHi - 1;
  localparam longint IntTermLim   = 64'sd1 << 48;
  localparam int     SettleCycles = 8;   // margin after the result queue empties

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        enc_count = '0;
  logic [8:0]         setpoint_rpm = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [6:0]         duty_percent;
  logic [14:0]        measured_rpm;
  logic signed [15:0] error_rpm;
  logic               speed_alarm;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor copy of the registers
  logic [31:0] prop_gain  = PropGainRst;
  logic [31:0] integ_gain = IntGainRst;
  logic [6:0]  base_duty  = BaseDutyRst;
  logic [14:0] err_limit  = ErrLimitRst;

  // Predictor copy of the controller state
  logic [15:0] last_count = '0;
  logic [14:0] speed_avg  = '0;
  int          err_sum    = 0;

  speed_update_t awaited_updates[$];
  int            failures = 0;

  // Idling controls: sender gaps and receiver stalls
  bit sender_gaps = 1'b1;
  bit recv_stalls = 1'b1;

  encoder_speed_pi_controller_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .enc_count     (enc_count),
    .setpoint_rpm  (setpoint_rpm),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .duty_percent  (duty_percent),
    .measured_rpm  (measured_rpm),
    .error_rpm     (error_rpm),
    .speed_alarm   (speed_alarm),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  // Work out one control tick: speed from the count step, smoothing, error,
  // warning, then the saturating PI law evaluated exactly in Q.24.
  function automatic speed_update_t control_update(input logic [15:0] cnt,
                                                   input logic [8:0]  sp);
    logic [15:0]   step;
    int unsigned   mag;
    int unsigned   raw_rpm;
    int unsigned   abs_err;
    int            err;
    longint        acc;
    longint        integ;
    longint        total;
    longint        kp;
    longint        ki;
    longint        base;
    speed_update_t upd;
    step = cnt - last_count;
    last_count = cnt;
    // A half-turn step (0x8000) has magnitude 32768
    mag = step[15] ? (32'h10000 - {16'h0, step}) : {16'h0, step};
    raw_rpm = mag * 6000 / 1120;
    if (raw_rpm > 32767)
      raw_rpm = 32767;
    speed_avg = 15'((7 * speed_avg + 3 * raw_rpm) / 10);
    err = $signed({1'b0, sp}) - $signed({1'b0, speed_avg});
    abs_err = (err < 0) ? -err : err;
    upd.rpm = speed_avg;
    upd.err = err[15:0];
    upd.warn = (abs_err > err_limit);
    if (sp == 0) begin
      // Stop: clear the integral and force the duty to zero
      err_sum = 0;
      upd.duty = '0;
    end else begin
      kp = prop_gain;
      ki = integ_gain;
      base = base_duty;
      acc = longint'(err_sum) + err;
      if (acc > SumHi)
        acc = SumHi;
      if (acc < SumLo)
        acc = SumLo;
      err_sum = int'(acc);
      integ = ki * acc;
      if (integ > IntTermLim)
        integ = IntTermLim;
      if (integ < -IntTermLim)
        integ = -IntTermLim;
      total = (base << 24) + kp * err + integ;
      if (total < 0)
        upd.duty = '0;
      else if ((total >>> 24) > 100)
        upd.duty = DutyMax;
      else
        upd.duty = 7'(total >>> 24);
    end
    return upd;
  endfunction

  // Receiver backpressure, redrawn every cycle
  always @(posedge clk)
    out_stall <= recv_stalls && ($urandom_range(99) < 29);

  task automatic report_mismatch(input string field, input logic signed [31:0] expv,
                                 input logic signed [31:0] gotv);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, gotv);
    failures++;
  endtask

  // Result checker: inputs only move at the rising edge, so the values seen at
  // the falling edge are the ones the next rising edge will act on.
  always @(negedge clk) begin
    speed_update_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_updates.size() == 0) begin
        $display("%0t: unexpected result transaction, duty %0d rpm %0d err %0d",
                 $time, duty_percent, measured_rpm, error_rpm);
        failures++;
      end else begin
        want = awaited_updates.pop_front();
        if (duty_percent !== want.duty)
          report_mismatch("duty_percent", want.duty, duty_percent);
        if (measured_rpm !== want.rpm)
          report_mismatch("measured_rpm", want.rpm, measured_rpm);
        if (error_rpm !== want.err)
          report_mismatch("error_rpm", $signed(want.err), error_rpm);
        if (speed_alarm !== want.warn)
          report_mismatch("speed_alarm", want.warn, speed_alarm);
      end
    end
  end

  // Send one tick; valid stays high on return so back-to-back ticks need
  // no second assignment in the same step.
  task automatic send_tick(input logic [15:0] cnt, input logic [8:0] sp);
    bit taken;
    if (sender_gaps)
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    enc_count <= cnt;
    setpoint_rpm <= sp;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    awaited_updates.push_back(control_update(cnt, sp));
  endtask

  // Drop valid and hold until every awaited update has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_updates.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    bit done;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    case (idx)
      REG_PROP_GAIN:        prop_gain = val;
      REG_INTEGRAL_GAIN_DT: integ_gain = val;
      REG_BASE_DUTY:        base_duty = val[6:0];
      REG_ERROR_LIMIT:      err_limit = val[14:0];
      default: ;
    endcase
  endtask

  // Reprogram all four registers with the pipeline empty
  task automatic configure(input logic [31:0] kp, input logic [31:0] ki,
                           input logic [6:0] base, input logic [14:0] lim);
    drain_results();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEGRAL_GAIN_DT, ki);
    write_reg(REG_BASE_DUTY, {25'h0, base});
    write_reg(REG_ERROR_LIMIT, {17'h0, lim});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(3))
      0:       return $urandom_range(0, 32'h0200_0000);
      1:       return $urandom;
      2:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(32'h00C0_0000, 32'h0140_0000);
    endcase
  endfunction

  // Reset gains: zero step, single counts both ways, half-turn steps, the rpm
  // saturation threshold, setpoint extremes and the stop setpoint.
  task automatic test_default_gains();
    send_tick(16'h0000, 9'd0);
    send_tick(16'h0001, 9'd300);
    send_tick(16'h0000, 9'd300);
    send_tick(16'h8000, 9'd300);
    send_tick(16'h8000 + 16'd6117, 9'd511);
    send_tick(16'h8000 + 16'd12233, 9'd511);
    send_tick(16'hFFFF, 9'd1);
    send_tick(16'h7FFF, 9'd0);
    send_tick(16'h7FFF, 9'd0);
    send_tick(16'h7FFF, 9'd1);
    send_tick(16'h8037, 9'd300);
    send_tick(16'h806F, 9'd300);
  endtask

  // Register extremes: full-scale gains and base above 100, then all zero
  // with the widest warning limit, then unity gains.
  task automatic test_register_extremes();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 15'd0);
    send_tick(16'h80A0, 9'd300);
    send_tick(16'h0000, 9'd511);
    send_tick(16'h0000, 9'd1);
    send_tick(16'h0400, 9'd1);
    configure(32'h0, 32'h0, 7'd0, 15'h7FFF);
    send_tick(16'h0400, 9'd200);
    send_tick(16'hC400, 9'd0);
    send_tick(16'hC400, 9'd511);
    configure(32'h0100_0000, 32'h0100_0000, DutyMax, 15'd100);
    send_tick(16'hC420, 9'd100);
    send_tick(16'hC3E0, 9'd50);
    send_tick(16'hC3E0, 9'd0);
  endtask

  // Spin flat out against a tiny setpoint so the error sum runs deep negative
  // and the integral term pins at its clamp, then stop and restart.
  // No idling on either side here.
  task automatic test_integral_saturation();
    logic [15:0] pos;
    logic [15:0] step;
    configure(pick_gain(), $urandom_range(32'h4000_0000, 32'hFFFF_FFFF), 7'd50, 15'd20);
    sender_gaps = 1'b0;
    recv_stalls = 1'b0;
    pos = last_count;
    repeat (250) begin
      step = 16'h4000 + 16'($urandom_range(0, 16'h1FFF));
      pos = $urandom_range(1) ? pos + step : pos - step;
      send_tick(pos, 9'($urandom_range(1, 20)));
    end
    send_tick(pos, 9'd0);
    send_tick(pos, 9'd300);
    sender_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // Mostly a motor tracking its setpoint with jitter, some reversal, plus
  // random jumps in the count; several register settings, extremes first.
  task automatic test_random_traffic();
    logic [15:0] pos;
    logic [15:0] step;
    logic [8:0]  sp;
    bit          backward;
    int          pick;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 15'd0);
        1:       configure(32'h0, 32'h0, 7'd0, 15'h7FFF);
        2:       configure(PropGainRst, IntGainRst, BaseDutyRst, ErrLimitRst);
        default: configure(pick_gain(), pick_gain(), 7'($urandom_range(0, 127)),
                           $urandom_range(2) == 0 ? 15'($urandom) :
                                                     15'($urandom_range(0, 60)));
      endcase
      pos = last_count;
      sp = 9'($urandom_range(1, 300));
      backward = $urandom_range(1);
      repeat (235) begin
        if ($urandom_range(99) < 5) begin
          pick = $urandom_range(99);
          if (pick < 10)
            sp = 9'd0;
          else if (pick < 15)
            sp = 9'($urandom_range(301, 511));
          else
            sp = 9'($urandom_range(1, 300));
          backward = ($urandom_range(9) == 0) ? !backward : backward;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          // count step that matches the setpoint speed, give or take a bit
          step = 16'((sp * 28) / 150 + $urandom_range(0, 6) - 3);
          pos = backward ? pos - step : pos + step;
        end else if (pick < 85) begin
          pos = 16'($urandom);
        end else begin
          pos = pos + 16'($urandom_range(0, 16'hFFFF));
        end
        send_tick(pos, sp);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_gains();
    test_register_extremes();
    test_integral_saturation();
    test_random_traffic();
    drain_results();
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/espc_pkg.sv
sv/encoder_speed_pi_controller_core.sv
bench/tb.sv
